[sv/perspective_project_to_screen_unit_defines.svh]
// ----------------------------------------------------------------------------
// Projection unit assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_PROJECT_TO_SCREEN_UNIT_DEFINES_SVH
`define PERSPECTIVE_PROJECT_TO_SCREEN_UNIT_DEFINES_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pps_pkg.sv]
// ----------------------------------------------------------------------------
// Projection unit package
// Types, constants and helper functions shared by the projection unit.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int MatrixEntries = 16;
   localparam int QueueDepth    = 4;
   localparam int DivBits       = 48;
   localparam int RegBits       = 14;
   localparam logic signed [31:0] WMinQ = 32'sd6554;
   localparam logic [RegBits-1:0] WidthReset  = 14'd1920;
   localparam logic [RegBits-1:0] HeightReset = 14'd1080;

   typedef enum logic {
      FUNC_LOAD    = 1'b0,
      FUNC_PROJECT = 1'b1
   } func_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               front;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cw;
   } q_item_type;

   typedef struct packed {
      logic               valid;
      logic               front;
      logic               negx;
      logic               negy;
      logic [31:0]        d;
      logic [31:0]        remx;
      logic [DivBits-1:0] qx;
      logic [31:0]        remy;
      logic [DivBits-1:0] qy;
   } div_stage_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647)
         r = 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

   // one restoring divide step on both quotients
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type r;
      logic [32:0] tx;
      logic [32:0] ty;
      r  = s;
      tx = {s.remx, s.qx[DivBits-1]};
      ty = {s.remy, s.qy[DivBits-1]};
      if (tx >= {1'b0, s.d}) begin
         tx = tx - {1'b0, s.d};
         r.qx = {s.qx[DivBits-2:0], 1'b1};
      end else begin
         r.qx = {s.qx[DivBits-2:0], 1'b0};
      end
      if (ty >= {1'b0, s.d}) begin
         ty = ty - {1'b0, s.d};
         r.qy = {s.qy[DivBits-2:0], 1'b1};
      end else begin
         r.qy = {s.qy[DivBits-2:0], 1'b0};
      end
      r.remx = tx[31:0];
      r.remy = ty[31:0];
      return r;
   endfunction

endpackage

[sv/pps_fifo.sv]
// ----------------------------------------------------------------------------
// Projection unit queue
// Small register queue between the clip front end and the divide back end.
// ----------------------------------------------------------------------------
`include "perspective_project_to_screen_unit_defines.svh"

module pps_fifo import pps_pkg::*; #(
   parameter int WIDTH = 97,
   parameter int DEPTH = QueueDepth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               push_data,
   input  logic                           pop,
   output logic [WIDTH-1:0]               pop_data,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   `PPS_ASSERT_NOW(a_no_overflow, push && !pop, count_ff != CntW'(DEPTH), "queue overflow")
   `PPS_ASSERT_NOW(a_no_underflow, pop, count_ff != '0, "queue underflow")
   `PPS_ASSERT_NEXT(a_count_track, push && !pop, count_ff == $past(count_ff) + CntW'(1),
      "queue count lost a push")

endmodule

[sv/pps_front.sv]
// ----------------------------------------------------------------------------
// Projection unit front end
// Holds the view matrix, takes items, forms clip x, y, w and the w test.
// ----------------------------------------------------------------------------
module pps_front import pps_pkg::*; #(
   parameter int DEPTH = QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [135:0]               req_tdata,
   input  logic                       req_tuser,
   input  logic [$clog2(DEPTH+1)-1:0] q_count,
   output logic                       q_push,
   output q_item_type                 q_item
);

   localparam int CntW = $clog2(DEPTH+1);

   logic signed [31:0] mat_ff [MatrixEntries];
   logic               acc;
   logic [3:0]         idx;
   logic signed [31:0] val, px, py, pz;

   logic               v1_ff;
   logic signed [63:0] p_ff [9];
   logic signed [31:0] off_ff [3];

   logic               v2_ff;
   q_item_type         item_ff, item_in;

   assign idx = req_tdata[3:0];
   assign val = req_tdata[35:4];
   assign px  = req_tdata[67:36];
   assign py  = req_tdata[99:68];
   assign pz  = req_tdata[131:100];

   assign req_tready = ({1'b0, q_count} + (CntW+1)'(v1_ff) + (CntW+1)'(v2_ff))
                       < (CntW+1)'(DEPTH);
   assign acc = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MatrixEntries; i++)
            mat_ff[i] <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (acc && func_type'(req_tuser) == FUNC_LOAD)
            mat_ff[idx] <= val;
         v1_ff <= acc && func_type'(req_tuser) == FUNC_PROJECT;
         v2_ff <= v1_ff;
      end
      // rows 0, 1 and 3
      for (int r = 0; r < 3; r++) begin
         p_ff[r*3]   <= px * mat_ff[(r == 2 ? 12 : r*4)];
         p_ff[r*3+1] <= py * mat_ff[(r == 2 ? 12 : r*4) + 1];
         p_ff[r*3+2] <= pz * mat_ff[(r == 2 ? 12 : r*4) + 2];
         off_ff[r]   <= mat_ff[(r == 2 ? 12 : r*4) + 3];
      end
      item_ff <= item_in;
   end

   always_comb begin
      logic signed [49:0] s [3];
      for (int r = 0; r < 3; r++)
         s[r] = 50'(p_ff[r*3] >>> 16) + 50'(p_ff[r*3+1] >>> 16)
              + 50'(p_ff[r*3+2] >>> 16) + 50'(off_ff[r]);
      item_in.cx    = sat32(64'(s[0]));
      item_in.cy    = sat32(64'(s[1]));
      item_in.cw    = sat32(64'(s[2]));
      item_in.front = item_in.cw >= WMinQ;
   end

   assign q_push = v2_ff;
   assign q_item = item_ff;

endmodule

[sv/pps_back.sv]
// ----------------------------------------------------------------------------
// Projection unit back end
// Pipelined divide by clip w, viewport scale and offset, output register.
// ----------------------------------------------------------------------------
`include "perspective_project_to_screen_unit_defines.svh"

module pps_back import pps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  q_item_type         q_item,
   output logic               q_pop,
   input  logic [12:0]        half_w,
   input  logic [12:0]        half_h,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,
   output logic               rsp_tuser
);

   logic               adv;
   div_stage_type      st_ff [DivBits+1];
   div_stage_type      st0_in;
   logic               pv_ff, pf_ff;
   logic signed [62:0] prx_ff, pry_ff;
   logic signed [48:0] nx, ny;
   logic               ov_ff, of_ff;
   logic signed [31:0] sx_ff, sy_ff, sx_in, sy_in;
   logic [31:0]        ax, ay;

   assign adv   = !ov_ff || rsp_tready;
   assign q_pop = adv && !q_empty;

   always_comb begin
      ax = q_item.cx[31] ? 32'(-{q_item.cx[31], q_item.cx}) : q_item.cx;
      ay = q_item.cy[31] ? 32'(-{q_item.cy[31], q_item.cy}) : q_item.cy;
      st0_in.valid = !q_empty;
      st0_in.front = q_item.front;
      st0_in.negx  = q_item.cx[31];
      st0_in.negy  = q_item.cy[31];
      st0_in.d     = q_item.cw;
      st0_in.remx  = '0;
      st0_in.qx    = {ax, 16'b0};
      st0_in.remy  = '0;
      st0_in.qy    = {ay, 16'b0};
      nx = st_ff[DivBits].negx ? -$signed({1'b0, st_ff[DivBits].qx})
                               : $signed({1'b0, st_ff[DivBits].qx});
      ny = st_ff[DivBits].negy ? -$signed({1'b0, st_ff[DivBits].qy})
                               : $signed({1'b0, st_ff[DivBits].qy});
      sx_in = sat32(64'(prx_ff) + $signed({35'b0, half_w, 16'b0}));
      sy_in = sat32(-64'(pry_ff) + $signed({35'b0, half_h, 16'b0}));
      if (!pf_ff) begin
         sx_in = '0;
         sy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DivBits; i++)
            st_ff[i].valid <= 1'b0;
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         st_ff[0] <= st0_in;
         for (int i = 1; i <= DivBits; i++)
            st_ff[i] <= div_step(st_ff[i-1]);
         pv_ff  <= st_ff[DivBits].valid;
         ov_ff  <= pv_ff;
         pf_ff  <= st_ff[DivBits].front;
         prx_ff <= $signed({1'b0, half_w}) * nx;
         pry_ff <= $signed({1'b0, half_h}) * ny;
         of_ff  <= pf_ff;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = of_ff;
   assign rsp_tdata  = {sy_ff, sx_ff};

   `PPS_ASSERT_NOW(a_behind_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0,
      "behind-viewer item carries nonzero position")
   `PPS_ASSERT_NEXT(a_hold_stall, rsp_tvalid && !rsp_tready, st_ff[0] === $past(st_ff[0]),
      "divide pipe moved during output stall")
   `PPS_ASSERT_NOW(a_pop_flows, q_pop, adv, "queue popped while pipe stalled")

endmodule

[sv/perspective_project_to_screen_unit.sv]
// ----------------------------------------------------------------------------
// Perspective projection unit
// Projects world points through a stored 4x4 view matrix to screen pixels.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tuser: func; tdata: index, value, x, y, z
//  rsp      out  rsp_tvalid/tready    tuser: in_front; tdata: screen_x, screen_y
//  csr      in   csr_we               csr_index, csr_wdata
//
//  One item per cycle while rsp is not stalled and the queue has room.
//  The divider is a 48-step pipeline, one quotient bit a stage.
//  Loads take effect for the next item and give no result.
//  Synchronous reset clears the matrix, sets 1920 x 1080 and empties the pipe.
//  A stalled rsp holds the whole back end; the 4-entry queue absorbs the front.
// ----------------------------------------------------------------------------
module perspective_project_to_screen_unit import pps_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [135:0]       req_tdata,   // entry_index, entry_value, pos_x, pos_y, pos_z
   input  logic               req_tuser,   // func
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,   // screen_x, screen_y
   output logic               rsp_tuser,   // in_front
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [RegBits-1:0] csr_wdata
);

   localparam int CntW = $clog2(QUEUE_DEPTH+1);

   logic [RegBits-1:0] width_ff, height_ff;
   logic               q_push, q_pop, q_empty;
   q_item_type         q_in, q_out;
   logic [CntW-1:0]    q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pps_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_item     (q_in)
   );

   pps_fifo #(.WIDTH($bits(q_item_type)), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty),
      .count     (q_count)
   );

   pps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (q_out),
      .q_pop      (q_pop),
      .half_w     (width_ff[RegBits-1:1]),
      .half_h     (height_ff[RegBits-1:1]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Projection unit testbench
// Loads view matrices, projects points and compares every screen result with
// a behavioral Q16.16 projection kept here, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb import pps_pkg::*; ();

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [135:0]       req_tdata = '0;  // entry_index, entry_value, pos_x, pos_y, pos_z
   logic               req_tuser = 1'b0; // func
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [63:0]        rsp_tdata;        // screen_x, screen_y
   logic               rsp_tuser;        // in_front
   logic               csr_we = 1'b0;
   logic               csr_index = 1'b0;
   logic [RegBits-1:0] csr_wdata = '0;

   typedef struct packed {
      logic               front;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
   } screen_point_type;

   logic signed [31:0] matrix [MatrixEntries];
   logic [RegBits-1:0] width_px;
   logic [RegBits-1:0] height_px;
   screen_point_type   expected_points [$];
   int                 mismatches = 0;
   int                 points_seen = 0;
   int                 loads_sent = 0;
   int                 hold_cycles = 0;
   bit                 random_stall = 1'b1;

   perspective_project_to_screen_unit dut (.*);

   always #10 clock = ~clock;

   function automatic logic signed [63:0] fix_floor(input logic signed [63:0] p);
      return p >>> 16;
   endfunction

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [63:0] clip_of(input int row,
         input logic signed [31:0] x, y, z);
      logic signed [63:0] s;
      s = fix_floor(64'(x) * 64'(matrix[row*4])) + fix_floor(64'(y) * 64'(matrix[row*4+1]))
        + fix_floor(64'(z) * 64'(matrix[row*4+2])) + 64'(matrix[row*4+3]);
      return clamp32(s);
   endfunction

   function automatic screen_point_type project_point(input logic signed [31:0] x, y, z);
      screen_point_type   r;
      logic signed [63:0] cx, cy, cw, nx, ny, hw, hh;
      cx = clip_of(0, x, y, z);
      cy = clip_of(1, x, y, z);
      cw = clip_of(3, x, y, z);
      r = '0;
      if (cw < 64'(WMinQ)) return r;
      nx = (cx * 64'sd65536) / cw;
      ny = (cy * 64'sd65536) / cw;
      hw = 64'(width_px / 2);
      hh = 64'(height_px / 2);
      r.front = 1'b1;
      r.sx = 32'(clamp32(hw * nx + hw * 64'sd65536));
      r.sy = 32'(clamp32(-(hh * ny) + hh * 64'sd65536));
      return r;
   endfunction

   task automatic send_item(input func_type f, input logic [3:0] idx,
         input logic signed [31:0] val, x, y, z);
      int gap;
      gap = random_stall ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {z, y, x, val, idx};
      do @(posedge clock); while (!req_tready);
      if (f == FUNC_LOAD) begin
         matrix[idx] = val;
         loads_sent++;
      end else begin
         expected_points.push_back(project_point(x, y, z));
      end
   endtask

   task automatic load_entry(input int idx, input logic signed [31:0] val);
      send_item(FUNC_LOAD, 4'(idx), val, $urandom, $urandom, $urandom);
   endtask

   task automatic send_point(input logic signed [31:0] x, y, z);
      send_item(FUNC_PROJECT, 4'($urandom), $urandom, x, y, z);
   endtask

   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [RegBits-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WIDTH) width_px = val; else height_px = val;
      @(posedge clock);
   endtask

   // perspective-like matrix: scale, w from z
   task automatic load_view(input int s);
      for (int i = 0; i < MatrixEntries; i++) begin
         case (i)
            0, 5:    load_entry(i, 32'sh10000 + $signed(32'($urandom_range(0, s))));
            3, 7:    load_entry(i, $signed(32'($urandom_range(0, 2*s))) - s);
            14:      load_entry(i, 32'sh10000);
            15:      load_entry(i, $signed(32'($urandom_range(0, 32'h40000))));
            default: load_entry(i, ($urandom_range(0, 3) == 0) ? $urandom : 0);
         endcase
      end
   endtask

   task automatic test_directed;
      // zero matrix: every point behind viewer
      send_point(0, 0, 0);
      load_entry(0, 32'sh10000);
      load_entry(5, 32'sh10000);
      load_entry(15, 32'sh10000);
      send_point(32'sh7FFFFFFF, 32'sh80000000, 0);
      send_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_point(32'sh8000, -32'sh8000, 0);
      load_entry(15, 32'sd6554);
      send_point(32'sh10000, 32'sh10000, 0);
      load_entry(15, 32'sd6553);
      send_point(32'sh10000, 32'sh10000, 0);
      load_entry(15, 32'sh80000000);
      send_point(1, 1, 1);
      load_entry(15, 32'sh7FFFFFFF);
      load_entry(3, 32'sh7FFFFFFF);
      load_entry(7, 32'sh80000000);
      send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
      load_entry(15, 32'sd6554);
      send_point(32'sh80000000, 32'sh80000000, -1);
   endtask

   task automatic test_screen_sizes;
      logic [RegBits-1:0] sizes [6] = '{14'd1, 14'd0, 14'd8192, 14'd16383, 14'd2, 14'd641};
      foreach (sizes[i]) begin
         wait_drained();
         write_csr(CSR_WIDTH, sizes[i]);
         write_csr(CSR_HEIGHT, sizes[5-i]);
         for (int k = 0; k < 8; k++) send_point($urandom, $urandom, $urandom);
         load_view(32'h20000);
         for (int k = 0; k < 12; k++)
            send_point($signed(32'($urandom_range(0, 32'h80000))) - 32'sh40000,
                       $signed(32'($urandom_range(0, 32'h80000))) - 32'sh40000,
                       $signed(32'($urandom_range(0, 32'h100000))));
      end
   endtask

   task automatic test_random_stream(input int n);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0:       load_entry($urandom_range(0, 15), $urandom);
            1:       send_point($urandom, $urandom, $urandom);
            2:       load_view(32'h80000);
            default: send_point($signed(32'($urandom_range(0, 32'h200000))) - 32'sh100000,
                                $signed(32'($urandom_range(0, 32'h200000))) - 32'sh100000,
                                $signed(32'($urandom_range(0, 32'h400000))) - 32'sh80000);
         endcase
      end
   endtask

   task automatic test_backpressure;
      wait_drained();
      random_stall = 1'b0;
      hold_cycles  = 200;
      for (int k = 0; k < 120; k++) send_point($urandom, $urandom, $urandom >> 8);
      random_stall = 1'b1;
   endtask

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= random_stall ? ($urandom_range(0, 5) == 0 ? 1'b0 : 1'b1) : 1'b1;
      end
   end

   always @(posedge clock) begin
      screen_point_type exp_pt;
      if (!reset && rsp_tvalid && rsp_tready) begin
         points_seen++;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h %h", rsp_tuser, rsp_tdata);
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_tuser !== exp_pt.front || rsp_tdata !== {exp_pt.sy, exp_pt.sx}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected front %b x %h y %h, got front %b x %h y %h",
                     exp_pt.front, exp_pt.sx, exp_pt.sy, rsp_tuser,
                     rsp_tdata[31:0], rsp_tdata[63:32]);
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("tb: errors");
      $finish;
   end

   initial begin
      foreach (matrix[i]) matrix[i] = '0;
      width_px  = WidthReset;
      height_px = HeightReset;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_screen_sizes();
      test_backpressure();
      wait_drained();
      write_csr(CSR_WIDTH, 14'd1920);
      write_csr(CSR_HEIGHT, 14'd1080);
      test_random_stream(280);
      wait_drained();
      if (expected_points.size() != 0) mismatches++;
      $display("covered %0d projected points and %0d matrix loads", points_seen, loads_sent);
      $display("six screen sizes, extremes included, plus a long output stall");
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
